// ===== rtl/core/gbepc_pkg.sv =====
// Shared types and constants for the grid boundary exit path counter.
// Used by the top level, the port checker and the testbench; no dependencies.
`default_nettype none

package gbepc_pkg;

	localparam int DEF_MAX_ROWS  = 64;
	localparam int DEF_MAX_COLS  = 64;
	localparam int DEF_MAX_MOVES = 64;

	localparam int DIM_W       = 7;
	localparam int START_W     = 6;
	localparam int COUNT_W     = 30;

	localparam logic [COUNT_W-1:0] EXIT_MODULUS = 30'd1000000007;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CELL,
		S_FIN_RD,
		S_FIN_WAIT,
		S_DONE
	} seq_state_t;

	// modular add of two residues below EXIT_MODULUS
	function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
			input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, EXIT_MODULUS}) begin
			s = s - {1'b0, EXIT_MODULUS};
		end
		return s[COUNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/grid_boundary_exit_path_count.sv =====
// Top level of the grid boundary exit path counter: sequencer, shared modular adder
// and two ping-pong layer memories. Depends on gbepc_pkg and gbepc_ram.
`default_nettype none

// Each request gives a grid (rows x cols, saturated to MAX_ROWS x MAX_COLS), a move
// budget (saturated to MAX_MOVES) and a start cell; the result is the number of move
// sequences of at most that many moves that leave the grid, modulo 1000000007. A start
// cell outside the grid answers 1 and a zero budget inside answers 0. Otherwise the
// block builds one layer per move, visiting each cell of the grid once per layer; the
// four neighbors of a cell pass one at a time through the single read port of the older
// layer and the one modular adder. Layer zero is implied, so no clearing pass follows
// reset. req_stall stays high while a request is in work; a finished result waits in
// the output register while the block takes the next request.
module grid_boundary_exit_path_count #(
	parameter int MAX_ROWS  = gbepc_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS  = gbepc_pkg::DEF_MAX_COLS,
	parameter int MAX_MOVES = gbepc_pkg::DEF_MAX_MOVES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [gbepc_pkg::DIM_W-1:0]         rows,
	input  logic [gbepc_pkg::DIM_W-1:0]         cols,
	input  logic [gbepc_pkg::DIM_W-1:0]         move_budget,
	input  logic [gbepc_pkg::START_W-1:0]       start_row,
	input  logic [gbepc_pkg::START_W-1:0]       start_col,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [gbepc_pkg::COUNT_W-1:0]       path_count
);

	import gbepc_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW    = $clog2(MAX_MOVES + 1);

	seq_state_t state_q, state_d;

	logic [DIM_W-1:0]   rows_q, cols_q;
	logic [MW-1:0]      budget_q, k_q;
	logic [AW-1:0]      start_addr_q;
	logic [DIM_W-1:0]   r_q, c_q;
	logic [AW-1:0]      addr_q, row_base_q;
	logic [2:0]         ph_q;
	logic               prev_in_q;
	logic [COUNT_W-1:0] acc_q, result_q, out_q;
	logic               out_valid_q;
	logic               rd_sel_q;

	logic [DIM_W-1:0]   rows_sat, cols_sat;
	logic [MW-1:0]      budget_sat;
	logic [31:0]        start_prod;
	logic               start_out;
	logic               nb_in;
	logic [AW-1:0]      nb_addr;
	logic               last_col, last_row, last_layer;
	logic               can_load;
	logic [COUNT_W-1:0] ram_rdata0, ram_rdata1, rdata_sel, contrib, acc_base, acc_sum;
	logic               we0, we1, rd_sel;
	logic [AW-1:0]      raddr;

	assign rows_sat   = ({2'b0, rows} > 9'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows;
	assign cols_sat   = ({2'b0, cols} > 9'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols;
	assign budget_sat = ({2'b0, move_budget} > 9'(MAX_MOVES)) ? MW'(MAX_MOVES)
		: MW'(move_budget);
	assign start_prod = 32'(start_row) * 32'(MAX_COLS) + 32'(start_col);
	assign start_out  = ({1'b0, start_row} >= rows_sat) || ({1'b0, start_col} >= cols_sat);

	assign last_col   = ({1'b0, c_q} + 8'd1) == {1'b0, cols_q};
	assign last_row   = ({1'b0, r_q} + 8'd1) == {1'b0, rows_q};
	assign last_layer = k_q == budget_q;
	assign can_load   = !out_valid_q || !res_stall;

	always_comb begin
		case (ph_q[1:0])
			2'd0: begin
				nb_in   = ({1'b0, r_q} + 8'd1) < {1'b0, rows_q};
				nb_addr = addr_q + AW'(MAX_COLS);
			end
			2'd1: begin
				nb_in   = r_q != '0;
				nb_addr = addr_q - AW'(MAX_COLS);
			end
			2'd2: begin
				nb_in   = ({1'b0, c_q} + 8'd1) < {1'b0, cols_q};
				nb_addr = addr_q + AW'(1);
			end
			default: begin
				nb_in   = c_q != '0;
				nb_addr = addr_q - AW'(1);
			end
		endcase
	end

	assign rdata_sel = rd_sel_q ? ram_rdata1 : ram_rdata0;
	assign contrib   = !prev_in_q ? COUNT_W'(1) : ((k_q == MW'(1)) ? '0 : rdata_sel);
	assign acc_base  = (ph_q == 3'd1) ? '0 : acc_q;
	assign acc_sum   = mod_add(acc_base, contrib);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (start_out || budget_sat == '0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_CELL;
					end
				end
			end
			S_CELL: begin
				if (ph_q == 3'd4 && last_col && last_row && last_layer) begin
					state_d = S_FIN_RD;
				end
			end
			S_FIN_RD:   state_d = S_FIN_WAIT;
			S_FIN_WAIT: state_d = S_DONE;
			S_DONE: begin
				if (can_load) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		we0       = 1'b0;
		we1       = 1'b0;
		rd_sel    = ~k_q[0];
		raddr     = nb_addr;
		unique case (state_q)
			S_IDLE: req_stall = 1'b0;
			S_CELL: begin
				we0 = (ph_q == 3'd4) && !k_q[0];
				we1 = (ph_q == 3'd4) && k_q[0];
			end
			S_FIN_RD: begin
				rd_sel = k_q[0];
				raddr  = start_addr_q;
			end
			S_FIN_WAIT, S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ph_q        <= '0;
			k_q         <= '0;
			r_q         <= '0;
			c_q         <= '0;
			addr_q      <= '0;
			row_base_q  <= '0;
			prev_in_q   <= 1'b0;
			rd_sel_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_sel_q <= rd_sel;

			if (state_q == S_DONE && can_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					k_q        <= MW'(1);
					r_q        <= '0;
					c_q        <= '0;
					addr_q     <= '0;
					row_base_q <= '0;
					ph_q       <= '0;
				end
				S_CELL: begin
					if (ph_q != 3'd4) begin
						prev_in_q <= nb_in;
						ph_q      <= ph_q + 3'd1;
					end else begin
						ph_q <= '0;
						if (!last_col) begin
							c_q    <= c_q + DIM_W'(1);
							addr_q <= addr_q + AW'(1);
						end else if (!last_row) begin
							c_q        <= '0;
							r_q        <= r_q + DIM_W'(1);
							row_base_q <= row_base_q + AW'(MAX_COLS);
							addr_q     <= row_base_q + AW'(MAX_COLS);
						end else if (!last_layer) begin
							c_q        <= '0;
							r_q        <= '0;
							row_base_q <= '0;
							addr_q     <= '0;
							k_q        <= k_q + MW'(1);
						end
					end
				end
				S_FIN_RD, S_FIN_WAIT, S_DONE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			rows_q       <= rows_sat;
			cols_q       <= cols_sat;
			budget_q     <= budget_sat;
			start_addr_q <= AW'(start_prod);
			result_q     <= start_out ? COUNT_W'(1) : '0;
		end
		if (state_q == S_CELL && ph_q != 3'd0) begin
			acc_q <= acc_sum;
		end
		if (state_q == S_FIN_WAIT) begin
			result_q <= rdata_sel;
		end
		if (state_q == S_DONE && can_load) begin
			out_q <= result_q;
		end
	end

	gbepc_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(DEPTH)
	) u_layer0 (
		.clk  (clk),
		.we   (we0),
		.waddr(addr_q),
		.wdata(acc_sum),
		.raddr(raddr),
		.rdata(ram_rdata0)
	);

	gbepc_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(DEPTH)
	) u_layer1 (
		.clk  (clk),
		.we   (we1),
		.waddr(addr_q),
		.wdata(acc_sum),
		.raddr(raddr),
		.rdata(ram_rdata1)
	);

	assign res_valid  = out_valid_q;
	assign path_count = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/gbepc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Holds one layer of per-cell exit counts; no package dependencies.
`default_nettype none

module gbepc_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/gbepc_checker.sv =====
// Port-level checker for the grid boundary exit path counter, bound to the top level.
// Depends on gbepc_pkg for the modulus.
`default_nettype none

module gbepc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  logic [gbepc_pkg::DIM_W-1:0]         rows,
	input  logic [gbepc_pkg::DIM_W-1:0]         cols,
	input  logic [gbepc_pkg::DIM_W-1:0]         move_budget,
	input  logic [gbepc_pkg::START_W-1:0]       start_row,
	input  logic [gbepc_pkg::START_W-1:0]       start_col,
	input  logic                                res_valid,
	input  logic                                res_stall,
	input  logic [gbepc_pkg::COUNT_W-1:0]       path_count
);

	import gbepc_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(path_count))
		else $error("result changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one still in work");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> path_count < EXIT_MODULUS)
		else $error("path count not reduced");

endmodule

bind grid_boundary_exit_path_count gbepc_checker u_gbepc_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for grid_boundary_exit_path_count: directed and random
// queries, a layered exit count predictor and random idle gaps on both channels.
// Depends on gbepc_pkg and the RTL of the block.

module tb;
	import gbepc_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int ROW_CAP        = DEF_MAX_ROWS;
	localparam int COL_CAP        = DEF_MAX_COLS;
	localparam int MOVE_CAP       = DEF_MAX_MOVES;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               req_valid   = 1'b0;
	logic               req_stall;
	logic [DIM_W-1:0]   rows        = '0;
	logic [DIM_W-1:0]   cols        = '0;
	logic [DIM_W-1:0]   move_budget = '0;
	logic [START_W-1:0] start_row   = '0;
	logic [START_W-1:0] start_col   = '0;
	logic               res_valid;
	logic               res_stall   = 1'b0;
	logic [COUNT_W-1:0] path_count;

	logic [COUNT_W-1:0] expected_counts[$];
	logic [COUNT_W-1:0] oldest_count;
	int                 mismatches  = 0;
	int                 idle_cycles = 0;
	int                 stall_left  = 0;
	bit                 steady      = 1'b0;

	grid_boundary_exit_path_count dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.rows        (rows),
		.cols        (cols),
		.move_budget (move_budget),
		.start_row   (start_row),
		.start_col   (start_col),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.path_count  (path_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [COUNT_W-1:0] count_exits(input logic [DIM_W-1:0] n_rows,
			input logic [DIM_W-1:0] n_cols, input logic [DIM_W-1:0] budget,
			input logic [START_W-1:0] row0, input logic [START_W-1:0] col0);
		int unsigned      prev_layer[ROW_CAP][COL_CAP];
		int unsigned      next_layer[ROW_CAP][COL_CAP];
		longint unsigned  acc;
		int               nr;
		int               nc;
		int               nb;
		nr = (n_rows > ROW_CAP) ? ROW_CAP : int'(n_rows);
		nc = (n_cols > COL_CAP) ? COL_CAP : int'(n_cols);
		nb = (budget > MOVE_CAP) ? MOVE_CAP : int'(budget);
		if (row0 >= nr || col0 >= nc) begin
			return COUNT_W'(1);
		end
		for (int r = 0; r < ROW_CAP; r++) begin
			for (int c = 0; c < COL_CAP; c++) begin
				prev_layer[r][c] = 0;
				next_layer[r][c] = 0;
			end
		end
		for (int k = 1; k <= nb; k++) begin
			for (int r = 0; r < nr; r++) begin
				for (int c = 0; c < nc; c++) begin
					acc = 0;
					acc += (r == 0)      ? 1 : prev_layer[r-1][c];
					acc += (r == nr - 1) ? 1 : prev_layer[r+1][c];
					acc += (c == 0)      ? 1 : prev_layer[r][c-1];
					acc += (c == nc - 1) ? 1 : prev_layer[r][c+1];
					next_layer[r][c] = int'(acc % EXIT_MODULUS);
				end
			end
			prev_layer = next_layer;
		end
		return prev_layer[row0][col0][COUNT_W-1:0];
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 9);
		if (steady || roll < 6) begin
			return 0;
		end else if (roll < 9) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
			input logic [COUNT_W-1:0] want);
		$display("%0t: %s: path_count got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// called right after a rising edge; leaves req_valid high after acceptance
	task automatic send_request(input logic [DIM_W-1:0] n_rows, input logic [DIM_W-1:0] n_cols,
			input logic [DIM_W-1:0] budget, input logic [START_W-1:0] row0,
			input logic [START_W-1:0] col0);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rows        <= n_rows;
		cols        <= n_cols;
		move_budget <= budget;
		start_row   <= row0;
		start_col   <= col0;
		req_valid   <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_counts.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_request();
		logic [DIM_W-1:0]   n_rows;
		logic [DIM_W-1:0]   n_cols;
		logic [DIM_W-1:0]   budget;
		logic [START_W-1:0] row0;
		logic [START_W-1:0] col0;
		int                 kind;
		int                 cost;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			n_rows = DIM_W'($urandom_range(1, 8));
			n_cols = DIM_W'($urandom_range(1, 8));
			budget = DIM_W'($urandom_range(0, 20));
			if ($urandom_range(0, 9) != 0) begin
				row0 = START_W'($urandom_range(0, n_rows - 1));
				col0 = START_W'($urandom_range(0, n_cols - 1));
			end else begin
				row0 = START_W'($urandom);
				col0 = START_W'($urandom);
			end
		end else if (kind < 85) begin
			n_rows = DIM_W'($urandom_range(1, 4));
			n_cols = DIM_W'($urandom_range(1, 4));
			budget = DIM_W'($urandom_range(30, 127));
			row0   = START_W'($urandom_range(0, n_rows - 1));
			col0   = START_W'($urandom_range(0, n_cols - 1));
		end else begin
			n_rows = DIM_W'($urandom);
			n_cols = DIM_W'($urandom);
			budget = DIM_W'($urandom);
			row0   = START_W'($urandom);
			col0   = START_W'($urandom);
			cost   = ((n_rows > ROW_CAP) ? ROW_CAP : int'(n_rows))
				* ((n_cols > COL_CAP) ? COL_CAP : int'(n_cols))
				* ((budget > MOVE_CAP) ? MOVE_CAP : int'(budget));
			// keep large inside queries short
			if (row0 < n_rows && col0 < n_cols && cost > 4096) begin
				budget = DIM_W'($urandom_range(0, 1));
			end
		end
		send_request(n_rows, n_cols, budget, row0, col0);
	endtask

	task automatic test_zero_budget();
		send_request(7'd1, 7'd1, 7'd0, 6'd0, 6'd0);
		send_request(7'd64, 7'd64, 7'd0, 6'd63, 6'd63);
		send_request(7'd5, 7'd7, 7'd0, 6'd2, 6'd3);
	endtask

	task automatic test_outside_start();
		send_request(7'd0, 7'd5, 7'd3, 6'd0, 6'd0);
		send_request(7'd5, 7'd0, 7'd3, 6'd0, 6'd0);
		send_request(7'd0, 7'd0, 7'd0, 6'd0, 6'd0);
		send_request(7'd2, 7'd3, 7'd0, 6'd63, 6'd0);
		send_request(7'd3, 7'd2, 7'd5, 6'd0, 6'd2);
		send_request(7'd3, 7'd4, 7'd127, 6'd3, 6'd0);
	endtask

	task automatic test_saturation();
		send_request(7'd127, 7'd1, 7'd3, 6'd63, 6'd0);
		send_request(7'd1, 7'd127, 7'd3, 6'd0, 6'd63);
		send_request(7'd100, 7'd100, 7'd1, 6'd32, 6'd32);
		send_request(7'd1, 7'd1, 7'd127, 6'd0, 6'd0);
		send_request(7'd2, 7'd2, 7'd65, 6'd1, 6'd1);
		send_request(7'd64, 7'd64, 7'd2, 6'd63, 6'd63);
	endtask

	task automatic test_small_grids();
		send_request(7'd1, 7'd1, 7'd1, 6'd0, 6'd0);
		send_request(7'd2, 7'd2, 7'd2, 6'd0, 6'd0);
		send_request(7'd1, 7'd3, 7'd4, 6'd0, 6'd1);
		send_request(7'd3, 7'd3, 7'd64, 6'd1, 6'd1);
		send_request(7'd8, 7'd8, 7'd64, 6'd0, 6'd7);
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 4; i++) begin
			send_random_request();
			wait_drained();
		end
	endtask

	task automatic test_random();
		for (int i = 0; i < 76; i++) begin
			steady = (i >= 30 && i < 50);
			send_random_request();
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (steady) begin
			res_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			res_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			res_stall  <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				expected_counts.push_back(count_exits(rows, cols, move_budget, start_row,
					start_col));
			end
			if (res_valid && !res_stall) begin
				if (expected_counts.size() == 0) begin
					report_mismatch("result with no request waiting", path_count, '0);
				end else begin
					oldest_count = expected_counts.pop_front();
					if (path_count !== oldest_count) begin
						report_mismatch("wrong count", path_count, oldest_count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_budget();
		test_outside_start();
		test_saturation();
		test_small_grids();
		test_drain_pause();
		test_random();
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_counts.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
